// File: rtl/gcbp_pkg.sv
// Package with shared constants, register indexes and helper functions for the glyph packer.
package gcbp_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int ROW_AW    = $clog2(MAX_ROWS);
  localparam int WORD_BITS = 32;
  localparam int DIM_W     = 6;
  localparam int PADDR_W   = 3;

  // Register index is byte address bit 2.
  localparam logic REG_GLYPH_WIDTH  = 1'b0;
  localparam logic REG_GLYPH_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 6'd8;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 6'd16;
  localparam logic [DIM_W-1:0] DIM_CAP      = 6'd32;

  // Clamps a width or height register to the range 1 to 32.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = 6'd1;
    end else if (v > DIM_CAP) begin
      r = DIM_CAP;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Ones in the top w bits of a word, w from 0 to 32.
  function automatic logic [WORD_BITS-1:0] top_mask(input logic [DIM_W-1:0] w);
    return ~({WORD_BITS{1'b1}} >> w);
  endfunction

endpackage

// File: rtl/gcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gcbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/glyph_crop_bitmap_pack.sv
// Top level of the glyph crop and bit pack block: row capture, bounding box scan and packer.
//
// Rows of a glyph are taken one per cycle (start high while busy is low),
// masked to the glyph width and written to a 32-row store, while the block
// keeps the first and last used row and the OR of all rows. After the last
// row busy goes high: a one-bit shifter walks the column mask, one
// column per cycle, up to the rightmost used column, then the S_SIZE
// state forms the box size and S_HDR emits the header beat. Each cropped
// row then passes through a row store read in S_READ and the 64-bit pack
// register in S_DATA, which appends the row and emits a word beat once a
// full word is held, and S_TAIL emits the zero-padded tail word if bits
// remain. An empty glyph emits its header beat straight from the capture
// path and busy never rises. Result beats are shown for one cycle on
// out_valid and cannot be held off by the receiver. The running bitmap
// offset advances by the byte size of each glyph and wraps at 16 bits.
// Width and height registers may be written between rows; each row uses
// the width in force when it arrives.
module glyph_crop_bitmap_pack (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gcbp_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Row input
  input  logic                            start,
  output logic                            busy,
  input  logic [gcbp_pkg::WORD_BITS-1:0]  in_row_bits,
  // Results
  output logic                            out_valid,
  output logic                            out_is_header,
  output logic [15:0]                     out_bitmap_offset,
  output logic [5:0]                      out_crop_width,
  output logic [5:0]                      out_crop_height,
  output logic [4:0]                      out_x_offset,
  output logic [4:0]                      out_y_offset,
  output logic [5:0]                      out_x_advance,
  output logic [gcbp_pkg::WORD_BITS-1:0]  out_bitmap_word,
  output logic [2:0]                      out_word_bytes,
  output logic                            out_last
);

  import gcbp_pkg::*;

  typedef enum logic [6:0] {
    S_ROWS = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_SIZE = 7'b0000100,
    S_HDR  = 7'b0001000,
    S_READ = 7'b0010000,
    S_DATA = 7'b0100000,
    S_TAIL = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [DIM_W-1:0] gw_r, gh_r;

  // Glyph capture state.
  logic [DIM_W-1:0]     row_count_r, row_count_nxt;
  logic                 any_r, any_nxt;
  logic [ROW_AW-1:0]    first_r, first_nxt;
  logic [ROW_AW-1:0]    lastrow_r, lastrow_nxt;
  logic [WORD_BITS-1:0] cm_r, cm_nxt;
  logic [15:0]          running_r, running_nxt;
  logic [DIM_W-1:0]     adv_r, adv_nxt;

  // Scan and pack state.
  logic [WORD_BITS-1:0] sh_r, sh_nxt;
  logic [4:0]           scan_j_r, scan_j_nxt;
  logic                 found_r, found_nxt;
  logic [4:0]           sc_r, sc_nxt;
  logic [4:0]           ec_r, ec_nxt;
  logic [DIM_W-1:0]     cw_r, cw_nxt;
  logic [DIM_W-1:0]     ch_r, ch_nxt;
  logic [7:0]           left_r, left_nxt;
  logic [ROW_AW-1:0]    ri_r, ri_nxt;
  logic [63:0]          buf_r, buf_nxt;
  logic [4:0]           n_r, n_nxt;

  // Result registers.
  logic                 ov_r, ov_nxt;
  logic                 ohdr_r, ohdr_nxt;
  logic [15:0]          ooff_r, ooff_nxt;
  logic [5:0]           ocw_r, ocw_nxt;
  logic [5:0]           och_r, och_nxt;
  logic [4:0]           oxo_r, oxo_nxt;
  logic [4:0]           oyo_r, oyo_nxt;
  logic [5:0]           oadv_r, oadv_nxt;
  logic [WORD_BITS-1:0] oword_r, oword_nxt;
  logic [2:0]           onb_r, onb_nxt;
  logic                 olast_r, olast_nxt;

  // Row store and datapath signals.
  logic                 ram_we, ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [DIM_W-1:0]     eff_w, eff_h;
  logic [WORD_BITS-1:0] row_m;
  logic [11:0]          prod;
  logic [11:0]          prod_rnd;
  logic [7:0]           bytes;
  logic [WORD_BITS-1:0] crop_v;
  logic [63:0]          merged;
  logic [5:0]           n_sum;
  logic [2:0]           nb;
  logic [7:0]           left_dec;

  gcbp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_count_r[ROW_AW-1:0]),
    .wdata (row_m),
    .re    (ram_re),
    .raddr (ri_r),
    .rdata (ram_rdata)
  );

  // Configuration port: always ready, writes on the access phase.
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_GLYPH_WIDTH:  prdata = {26'd0, gw_r};
      REG_GLYPH_HEIGHT: prdata = {26'd0, gh_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= WIDTH_RESET;
      gh_r <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_GLYPH_WIDTH:  gw_r <= pwdata[DIM_W-1:0];
        REG_GLYPH_HEIGHT: gh_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w = clamp_dim(gw_r);
  assign eff_h = clamp_dim(gh_r);
  assign row_m = in_row_bits & top_mask(eff_w);

  // Box byte size: one small multiply, then round up to whole bytes.
  assign prod     = {6'd0, cw_r} * {6'd0, ch_r};
  assign prod_rnd = prod + 12'd7;
  assign bytes    = prod_rnd[10:3];

  // Packer: crop the row to the box columns and append it after the n_r held bits.
  assign crop_v   = (ram_rdata << sc_r) & top_mask(cw_r);
  assign merged   = buf_r | ({crop_v, 32'd0} >> n_r);
  assign n_sum    = {1'b0, n_r} + cw_r;
  assign nb       = (left_r > 8'd4) ? 3'd4 : left_r[2:0];
  assign left_dec = left_r - {5'd0, nb};

  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    any_nxt       = any_r;
    first_nxt     = first_r;
    lastrow_nxt   = lastrow_r;
    cm_nxt        = cm_r;
    running_nxt   = running_r;
    adv_nxt       = adv_r;
    sh_nxt        = sh_r;
    scan_j_nxt    = scan_j_r;
    found_nxt     = found_r;
    sc_nxt        = sc_r;
    ec_nxt        = ec_r;
    cw_nxt        = cw_r;
    ch_nxt        = ch_r;
    left_nxt      = left_r;
    ri_nxt        = ri_r;
    buf_nxt       = buf_r;
    n_nxt         = n_r;
    ov_nxt        = 1'b0;
    ohdr_nxt      = 1'b0;
    ooff_nxt      = '0;
    ocw_nxt       = '0;
    och_nxt       = '0;
    oxo_nxt       = '0;
    oyo_nxt       = '0;
    oadv_nxt      = '0;
    oword_nxt     = '0;
    onb_nxt       = '0;
    olast_nxt     = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      S_ROWS: begin
        if (start) begin
          ram_we        = 1'b1;
          row_count_nxt = row_count_r + 6'd1;
          cm_nxt        = cm_r | row_m;
          if (row_m != '0) begin
            if (!any_r) begin
              first_nxt = row_count_r[ROW_AW-1:0];
            end
            any_nxt     = 1'b1;
            lastrow_nxt = row_count_r[ROW_AW-1:0];
          end
          if (row_count_nxt >= eff_h) begin
            adv_nxt = eff_w;
            if (!any_nxt) begin
              // Empty glyph: header only, and the glyph state starts over.
              ov_nxt        = 1'b1;
              ohdr_nxt      = 1'b1;
              ooff_nxt      = running_r;
              oadv_nxt      = eff_w;
              olast_nxt     = 1'b1;
              row_count_nxt = '0;
              cm_nxt        = '0;
              any_nxt       = 1'b0;
              first_nxt     = '0;
              lastrow_nxt   = '0;
            end else begin
              sh_nxt     = cm_nxt;
              scan_j_nxt = '0;
              found_nxt  = 1'b0;
              state_nxt  = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (sh_r[WORD_BITS-1]) begin
          if (!found_r) begin
            sc_nxt    = scan_j_r;
            found_nxt = 1'b1;
          end
          ec_nxt = scan_j_r;
        end
        sh_nxt     = {sh_r[WORD_BITS-2:0], 1'b0};
        scan_j_nxt = scan_j_r + 5'd1;
        if (sh_nxt == '0) begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        cw_nxt    = {1'b0, ec_r} - {1'b0, sc_r} + 6'd1;
        ch_nxt    = {1'b0, lastrow_r} - {1'b0, first_r} + 6'd1;
        state_nxt = S_HDR;
      end
      S_HDR: begin
        ov_nxt      = 1'b1;
        ohdr_nxt    = 1'b1;
        ooff_nxt    = running_r;
        ocw_nxt     = cw_r;
        och_nxt     = ch_r;
        oxo_nxt     = sc_r;
        oyo_nxt     = first_r;
        oadv_nxt    = adv_r;
        running_nxt = running_r + {8'd0, bytes};
        left_nxt    = bytes;
        ri_nxt      = first_r;
        buf_nxt     = '0;
        n_nxt       = '0;
        state_nxt   = S_READ;
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        if (n_sum[5]) begin
          ov_nxt    = 1'b1;
          oword_nxt = merged[63:32];
          onb_nxt   = nb;
          olast_nxt = (left_dec == '0);
          left_nxt  = left_dec;
          buf_nxt   = {merged[31:0], 32'd0};
        end else begin
          buf_nxt = merged;
        end
        n_nxt = n_sum[4:0];
        if (ri_r == lastrow_r) begin
          state_nxt = S_TAIL;
        end else begin
          ri_nxt    = ri_r + ROW_AW'(1);
          state_nxt = S_READ;
        end
      end
      S_TAIL: begin
        if (n_r != '0) begin
          ov_nxt    = 1'b1;
          oword_nxt = buf_r[63:32];
          onb_nxt   = left_r[2:0];
          olast_nxt = 1'b1;
        end
        row_count_nxt = '0;
        cm_nxt        = '0;
        any_nxt       = 1'b0;
        first_nxt     = '0;
        lastrow_nxt   = '0;
        state_nxt     = S_ROWS;
      end
      default: begin
        state_nxt = S_ROWS;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ROWS;
      row_count_r <= '0;
      any_r       <= 1'b0;
      first_r     <= '0;
      lastrow_r   <= '0;
      cm_r        <= '0;
      running_r   <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      any_r       <= any_nxt;
      first_r     <= first_nxt;
      lastrow_r   <= lastrow_nxt;
      cm_r        <= cm_nxt;
      running_r   <= running_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // Datapath and result payload.
  always_ff @(posedge clk) begin
    adv_r    <= adv_nxt;
    sh_r     <= sh_nxt;
    scan_j_r <= scan_j_nxt;
    found_r  <= found_nxt;
    sc_r     <= sc_nxt;
    ec_r     <= ec_nxt;
    cw_r     <= cw_nxt;
    ch_r     <= ch_nxt;
    left_r   <= left_nxt;
    ri_r     <= ri_nxt;
    buf_r    <= buf_nxt;
    n_r      <= n_nxt;
    ohdr_r   <= ohdr_nxt;
    ooff_r   <= ooff_nxt;
    ocw_r    <= ocw_nxt;
    och_r    <= och_nxt;
    oxo_r    <= oxo_nxt;
    oyo_r    <= oyo_nxt;
    oadv_r   <= oadv_nxt;
    oword_r  <= oword_nxt;
    onb_r    <= onb_nxt;
    olast_r  <= olast_nxt;
  end

  assign busy              = (state_r != S_ROWS);
  assign out_valid         = ov_r;
  assign out_is_header     = ohdr_r;
  assign out_bitmap_offset = ooff_r;
  assign out_crop_width    = ocw_r;
  assign out_crop_height   = och_r;
  assign out_x_offset      = oxo_r;
  assign out_y_offset      = oyo_r;
  assign out_x_advance     = oadv_r;
  assign out_bitmap_word   = oword_r;
  assign out_word_bytes    = onb_r;
  assign out_last          = olast_r;

endmodule

// File: rtl/gcbp_chk.sv
// Port-level assertion checker for the glyph packer, bound to the top level.
module gcbp_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_is_header,
  input logic [2:0]                      out_word_bytes,
  input logic                            out_last
);

  // A bitmap word beat carries one to four valid bytes.
  a_word_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_header |-> out_word_bytes != 3'd0 && out_word_bytes <= 3'd4)
    else $error("bitmap word beat with bad byte count");

  // The sequencer only leaves capture after an accepted row.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a row beat");

  // After a header of a non-empty glyph the packer is still working.
  a_hdr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header && !out_last |=> busy)
    else $error("block idle after header of non-empty glyph");

  // While a word beat that is not the last is shown, the packer is still working.
  a_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_header && !out_last |-> busy)
    else $error("block idle before final word beat");

endmodule

bind glyph_crop_bitmap_pack gcbp_chk u_gcbp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_is_header  (out_is_header),
  .out_word_bytes (out_word_bytes),
  .out_last       (out_last)
);

// File: tb/glyph_crop_bitmap_pack_checker.sv
// Checker that predicts the header and packed bitmap beats of the glyph packer and compares them.
module glyph_crop_bitmap_pack_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic                                   pready,
  input  logic [gcbp_pkg::PADDR_W-1:0]           paddr,
  input  logic [31:0]                            pwdata,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic [31:0]                            in_row_bits,
  input  logic                                   out_valid,
  input  logic                                   out_is_header,
  input  logic [15:0]                            out_bitmap_offset,
  input  logic [5:0]                             out_crop_width,
  input  logic [5:0]                             out_crop_height,
  input  logic [4:0]                             out_x_offset,
  input  logic [4:0]                             out_y_offset,
  input  logic [5:0]                             out_x_advance,
  input  logic [31:0]                            out_bitmap_word,
  input  logic [2:0]                             out_word_bytes,
  input  logic                                   out_last,
  output int                                     fail_count,
  output int                                     beats_outstanding,
  output int                                     beats_checked,
  output int                                     headers_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NO_ROW = 32;

  typedef struct {
    logic        is_header;
    logic [15:0] bitmap_offset;
    logic [5:0]  crop_width;
    logic [5:0]  crop_height;
    logic [4:0]  x_offset;
    logic [4:0]  y_offset;
    logic [5:0]  x_advance;
    logic [31:0] bitmap_word;
    logic [2:0]  word_bytes;
    logic        last;
  } glyph_beat_t;

  glyph_beat_t beats_due[$];
  glyph_beat_t want_beat;

  logic [31:0] row_mem [gcbp_pkg::MAX_ROWS];
  int          rows_held;
  int          top_row;
  int          bottom_row;
  int          bytes_owed;
  logic [31:0] used_cols;
  logic [15:0] byte_offset;
  logic [5:0]  width_reg;
  logic [5:0]  height_reg;

  initial begin
    fail_count        = 0;
    beats_outstanding = 0;
    beats_checked     = 0;
    headers_checked   = 0;
  end

  // Out-of-range register values fold into 1..32.
  function automatic int clip_dim(input logic [5:0] v);
    if (v == 6'd0) return 1;
    if (v > 6'd32) return 32;
    return int'(v);
  endfunction

  function automatic int miss(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic start_glyph();
    rows_held  = 0;
    top_row    = NO_ROW;
    bottom_row = 0;
    used_cols  = '0;
  endtask

  task automatic push_word(input logic [31:0] word);
    glyph_beat_t b;
    int nb;
    b = '{default: '0};
    nb = (bytes_owed > 4) ? 4 : bytes_owed;
    bytes_owed -= nb;
    b.bitmap_word = word;
    b.word_bytes  = 3'(nb);
    b.last        = (bytes_owed == 0);
    beats_due.push_back(b);
  endtask

  // Stores one row and, when it closes the glyph, queues the header and
  // the packed words of the cropped box.
  task automatic capture_row(input logic [31:0] raw);
    glyph_beat_t hdr;
    logic [31:0] row;
    logic [31:0] shifted;
    logic [63:0] pack_acc;
    int w, sc, ec, cw, ch, bits_held;
    w = clip_dim(width_reg);
    row = raw & ~(32'hFFFF_FFFF >> w);
    row_mem[rows_held] = row;
    if (row != '0) begin
      if (top_row == NO_ROW) top_row = rows_held;
      bottom_row = rows_held;
    end
    used_cols |= row;
    rows_held++;
    if (rows_held < clip_dim(height_reg)) return;

    hdr = '{default: '0};
    hdr.is_header     = 1'b1;
    hdr.bitmap_offset = byte_offset;
    hdr.x_advance     = 6'(w);
    if (top_row == NO_ROW) begin
      hdr.last = 1'b1;
      beats_due.push_back(hdr);
      start_glyph();
      return;
    end

    sc = 0;
    while (sc < 31 && !used_cols[31-sc]) sc++;
    ec = 31;
    while (ec > sc && !used_cols[31-ec]) ec--;
    cw = ec - sc + 1;
    ch = bottom_row - top_row + 1;
    bytes_owed = (cw * ch + 7) / 8;
    hdr.crop_width  = 6'(cw);
    hdr.crop_height = 6'(ch);
    hdr.x_offset    = 5'(sc);
    hdr.y_offset    = 5'(top_row);
    beats_due.push_back(hdr);
    byte_offset = byte_offset + 16'(bytes_owed);

    pack_acc  = '0;
    bits_held = 0;
    for (int i = top_row; i <= bottom_row; i++) begin
      shifted   = row_mem[i] << sc;
      pack_acc  = (pack_acc << cw) | ({32'd0, shifted} >> (32 - cw));
      bits_held += cw;
      while (bits_held >= 32) begin
        bits_held -= 32;
        push_word(32'(pack_acc >> bits_held));
        pack_acc &= (64'd1 << bits_held) - 64'd1;
      end
    end
    if (bits_held > 0) push_word(32'(pack_acc << (32 - bits_held)));
    start_glyph();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      beats_due.delete();
      start_glyph();
      byte_offset = '0;
      width_reg   = gcbp_pkg::WIDTH_RESET;
      height_reg  = gcbp_pkg::HEIGHT_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == gcbp_pkg::REG_GLYPH_WIDTH) width_reg = pwdata[5:0];
        else height_reg = pwdata[5:0];
      end
      if (start && !busy) capture_row(in_row_bits);
      if (out_valid) begin
        if (beats_due.size() == 0) begin
          $error("Result beat with nothing expected: header %0b, word 0x%08h",
                 out_is_header, out_bitmap_word);
          fail_count++;
        end else begin
          want_beat = beats_due.pop_front();
          fail_count += miss("is_header", want_beat.is_header, out_is_header);
          fail_count += miss("bitmap_offset", want_beat.bitmap_offset, out_bitmap_offset);
          fail_count += miss("crop_width", want_beat.crop_width, out_crop_width);
          fail_count += miss("crop_height", want_beat.crop_height, out_crop_height);
          fail_count += miss("x_offset", want_beat.x_offset, out_x_offset);
          fail_count += miss("y_offset", want_beat.y_offset, out_y_offset);
          fail_count += miss("x_advance", want_beat.x_advance, out_x_advance);
          fail_count += miss("bitmap_word", want_beat.bitmap_word, out_bitmap_word);
          fail_count += miss("word_bytes", want_beat.word_bytes, out_word_bytes);
          fail_count += miss("last", want_beat.last, out_last);
          beats_checked++;
          if (want_beat.is_header) headers_checked++;
        end
      end
    end
    beats_outstanding = beats_due.size();
  end

endmodule

// File: tb/glyph_crop_bitmap_pack_tb.sv
// Top of the glyph packer testbench: clock, reset, row and register stimulus, and the verdict.
module glyph_crop_bitmap_pack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Random rows after the directed part.
  localparam int RANDOM_ROWS = 30;
  // A full 32x32 box gives the most beats a glyph can give.
  localparam int FULL_GLYPHS = 1;
  // The drain at the end waits longer than a tall glyph keeps the block
  // busy, to catch any stray beat.
  localparam int DRAIN_CYCLES = 200;
  // The limit sits well above the length of the whole run, even with the
  // longest idle gaps on every row.
  localparam int CYCLE_LIMIT = 40000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [gcbp_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start       = 1'b0;
  logic        busy;
  logic [31:0] in_row_bits = '0;

  logic        out_valid;
  logic        out_is_header;
  logic [15:0] out_bitmap_offset;
  logic [5:0]  out_crop_width;
  logic [5:0]  out_crop_height;
  logic [4:0]  out_x_offset;
  logic [4:0]  out_y_offset;
  logic [5:0]  out_x_advance;
  logic [31:0] out_bitmap_word;
  logic [2:0]  out_word_bytes;
  logic        out_last;

  int fail_count;
  int beats_outstanding;
  int beats_checked;
  int headers_checked;

  // Stimulus bookkeeping: the register values last written, how far into
  // the current glyph the row stream is, and the burst shaping of the sender.
  logic [5:0] width_now  = gcbp_pkg::WIDTH_RESET;
  logic [5:0] height_now = gcbp_pkg::HEIGHT_RESET;
  int rows_in_glyph = 0;
  int rows_sent     = 0;
  int full_rows     = 0;
  int reg_writes    = 0;
  int burst_left    = 0;
  int cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glyph_crop_bitmap_pack uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .in_row_bits       (in_row_bits),
    .out_valid         (out_valid),
    .out_is_header     (out_is_header),
    .out_bitmap_offset (out_bitmap_offset),
    .out_crop_width    (out_crop_width),
    .out_crop_height   (out_crop_height),
    .out_x_offset      (out_x_offset),
    .out_y_offset      (out_y_offset),
    .out_x_advance     (out_x_advance),
    .out_bitmap_word   (out_bitmap_word),
    .out_word_bytes    (out_word_bytes),
    .out_last          (out_last)
  );

  glyph_crop_bitmap_pack_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .start             (start),
    .busy              (busy),
    .in_row_bits       (in_row_bits),
    .out_valid         (out_valid),
    .out_is_header     (out_is_header),
    .out_bitmap_offset (out_bitmap_offset),
    .out_crop_width    (out_crop_width),
    .out_crop_height   (out_crop_height),
    .out_x_offset      (out_x_offset),
    .out_y_offset      (out_y_offset),
    .out_x_advance     (out_x_advance),
    .out_bitmap_word   (out_bitmap_word),
    .out_word_bytes    (out_word_bytes),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .beats_outstanding (beats_outstanding),
    .beats_checked     (beats_checked),
    .headers_checked   (headers_checked)
  );

  // Hard stop in case the block hangs or never drains its results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit of %0d cycles.", CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Rows per glyph as the block sees the height register: zero acts as one
  // and anything above the row store depth acts as the full depth.
  function automatic int rows_per_glyph();
    if (height_now == 6'd0) return 1;
    if (height_now > 6'(gcbp_pkg::MAX_ROWS)) return gcbp_pkg::MAX_ROWS;
    return int'(height_now);
  endfunction

  // Waits until every expected beat has come out and the block has dropped
  // busy, then lets the clock run on so that any trailing work is over.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (beats_outstanding != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Register write with a setup and an access phase. The upper data bits
  // are sometimes random, since only the low six bits belong to a register.
  task automatic write_reg(input logic idx, input logic [5:0] value);
    settle();
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom_range(0, 1) ? ($urandom & 32'hFFFF_FFC0) : 32'd0) | 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == gcbp_pkg::REG_GLYPH_WIDTH) width_now = value;
    else height_now = value;
    reg_writes++;
  endtask

  // Sends one row beat. The sender works in bursts: when a burst runs out
  // it idles for a random gap (start low, data scrambled) and picks a new
  // burst length, now and then a long one with no idling at all.
  task automatic feed_row(input logic [31:0] bits);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk);
        start       = 1'b0;
        in_row_bits = $urandom;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk);
    start       = 1'b1;
    in_row_bits = bits;
    // Busy only changes at a rising edge, so seeing it low here means the
    // beat is taken at the coming edge.
    while (busy) @(negedge clk);
    @(posedge clk);
    rows_sent++;
    rows_in_glyph++;
    if (rows_in_glyph >= rows_per_glyph()) rows_in_glyph = 0;
  endtask

  // Row contents: empty, dense, full, a single pixel, sparse, and rows
  // with blank columns on the left.
  function automatic logic [31:0] make_row();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd1 << $urandom_range(0, 31);
      4:       return $urandom & $urandom & $urandom;
      default: return $urandom >> $urandom_range(1, 31);
    endcase
  endfunction

  function automatic logic [5:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      2:       return 6'd32;
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  // Mostly short glyphs so that many headers come out of a modest row count.
  function automatic logic [5:0] pick_height();
    case ($urandom_range(0, 11))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      2:       return 6'($urandom_range(7, 32));
      3:       return 6'd1;
      default: return 6'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    int random_mark;
    logic [31:0] bits;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Single-row glyphs at full width: a full row, an empty glyph (header
    // only), the two outermost columns, and the rightmost column alone.
    write_reg(gcbp_pkg::REG_GLYPH_WIDTH, 6'd32);
    write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'd1);
    feed_row(32'hFFFF_FFFF);
    feed_row(32'h0000_0000);
    feed_row(32'h8000_0001);
    feed_row(32'h0000_0001);

    // Zero width and zero height both act as one.
    write_reg(gcbp_pkg::REG_GLYPH_WIDTH, 6'd0);
    write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'd0);
    feed_row(32'hFFFF_FFFF);
    feed_row(32'h7FFF_FFFF);

    // Width above the cap acts as 32; a two-row box spanning all columns.
    write_reg(gcbp_pkg::REG_GLYPH_WIDTH, 6'd63);
    write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'd2);
    feed_row(32'h0000_0001);
    feed_row(32'h8000_0000);

    // Narrow glyph: bits past the width are dropped on arrival, and a blank
    // row sits inside the box.
    write_reg(gcbp_pkg::REG_GLYPH_WIDTH, 6'd5);
    write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'd3);
    feed_row(32'hFFFF_FFFF);
    feed_row(32'h0000_0000);
    feed_row(32'h0800_0000);

    // Height lowered mid-glyph: the glyph ends with the next row.
    write_reg(gcbp_pkg::REG_GLYPH_WIDTH, 6'd8);
    write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'd4);
    feed_row(32'h0000_0000);
    feed_row(32'h0F00_0000);
    feed_row(32'h0000_0000);
    write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'd2);
    feed_row(32'h0100_0000);

    // Width changed mid-glyph: each row keeps the width it arrived with,
    // and the advance follows the width at the last row.
    write_reg(gcbp_pkg::REG_GLYPH_WIDTH, 6'd16);
    write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'd2);
    feed_row(32'hFFFF_FFFF);
    write_reg(gcbp_pkg::REG_GLYPH_WIDTH, 6'd4);
    feed_row(32'hFFFF_FFFF);

    // Tallest glyphs. The first holds a single pixel in the bottom-right
    // corner, so both offsets reach their maximum. Then a full 32x32 box
    // with a random interior, which gives the most beats a glyph can give.
    write_reg(gcbp_pkg::REG_GLYPH_WIDTH, 6'd32);
    write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'd32);
    for (int r = 0; r < gcbp_pkg::MAX_ROWS; r++) begin
      feed_row((r == gcbp_pkg::MAX_ROWS - 1) ? 32'h0000_0001 : 32'h0000_0000);
    end
    for (int g = 0; g < FULL_GLYPHS; g++) begin
      for (int r = 0; r < gcbp_pkg::MAX_ROWS; r++) begin
        bits = $urandom;
        if (r == 0 || r == gcbp_pkg::MAX_ROWS - 1) bits |= 32'h8000_0001;
        feed_row(bits);
        full_rows++;
      end
    end

    // Random part: new settings between groups of glyphs, random row
    // contents, and now and then a register change in the middle of a glyph.
    random_mark = rows_sent;
    while (rows_sent - random_mark < RANDOM_ROWS) begin
      if ($urandom_range(0, 2) != 0) write_reg(gcbp_pkg::REG_GLYPH_WIDTH, pick_width());
      if ($urandom_range(0, 2) != 0) write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, pick_height());
      repeat ($urandom_range(1, 3)) begin
        do begin
          feed_row(make_row());
          if (rows_in_glyph != 0 && $urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 1) != 0) begin
              write_reg(gcbp_pkg::REG_GLYPH_WIDTH, pick_width());
            end else begin
              write_reg(gcbp_pkg::REG_GLYPH_HEIGHT, 6'($urandom_range(1, rows_in_glyph)));
            end
          end
        end while (rows_in_glyph != 0);
      end
    end

    // Drain: everything predicted must have come out, then watch a while
    // longer for any beat nobody asked for.
    @(negedge clk);
    start = 1'b0;
    while (beats_outstanding != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d rows (%0d of them in full 32x32 boxes) "
             , rows_sent, full_rows);
    $display("and %0d register writes; %0d result beats checked, %0d of them headers.",
             reg_writes, beats_checked, headers_checked);
    if (fail_count == 0 && beats_outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
